FILE: sv/mva_pkg.sv
package mva_pkg;

	localparam int VOICE_COUNT = 16;
	localparam int KNOB_COUNT = 8;
	localparam int PAGE_COUNT = 4;
	localparam int MAX_RESULTS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam int VOICE_W = $clog2(VOICE_COUNT);
	localparam int KIDX_W = $clog2(KNOB_COUNT);
	localparam int SLOT_COUNT = PAGE_COUNT * KNOB_COUNT;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// free marker in a voice entry
	localparam logic [7:0] VOICE_FREE = 8'h80;

	// midi commands, status bits 6:4
	localparam logic [2:0] MIDI_NOTE_OFF = 3'd0;
	localparam logic [2:0] MIDI_NOTE_ON = 3'd1;
	localparam logic [2:0] MIDI_CTRL = 3'd3;
	localparam logic [2:0] MIDI_BEND = 3'd6;

	// controller numbers
	localparam logic [6:0] CC_MOD = 7'd1;
	localparam logic [6:0] CC_PWM = 7'd2;
	localparam logic [6:0] CC_WAVE_A = 7'd64;
	localparam logic [6:0] CC_WAVE_B = 7'd65;
	localparam logic [6:0] CC_PAGE0 = 7'd97;
	localparam logic [6:0] CC_PAGE1 = 7'd96;
	localparam logic [6:0] CC_PAGE2 = 7'd66;
	localparam logic [6:0] CC_PAGE3 = 7'd67;

	localparam logic [6:0] KNOB_CCS [8] = '{7'd91, 7'd93, 7'd74, 7'd71,
		7'd73, 7'd75, 7'd72, 7'd10};

	// configuration register indexes
	localparam logic CFG_PERC = 1'b0;
	localparam logic CFG_TOL = 1'b1;

	localparam logic [3:0] PERC_RESET = 4'd10;
	localparam logic [6:0] TOL_RESET = 7'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_NOTE_OFF,
		OP_NOTE_ON,
		OP_BEND,
		OP_MOD,
		OP_PWM,
		OP_WAVE,
		OP_PAGE,
		OP_KNOB
	} op_t;

	typedef struct packed {
		op_t op;
		logic [6:0] a;
		logic [6:0] b;
		logic [2:0] sel;
	} cmd_t;

	typedef enum logic [2:0] {
		EV_ON = 3'd0,
		EV_OFF = 3'd1,
		EV_BEND = 3'd2,
		EV_MOD = 3'd3,
		EV_PWM = 3'd4,
		EV_WAVE = 3'd5,
		EV_KNOB = 3'd6,
		EV_PAGE = 3'd7
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t kind;
		logic [3:0] voice;
		logic [6:0] note;
		logic [6:0] vel;
		logic [13:0] cval;
		logic [1:0] page;
		logic [2:0] knob;
		logic last;
	} res_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_OFF_SCAN,
		BK_ON_SCAN,
		BK_ON_EMIT,
		BK_SINGLE
	} bk_state_t;

	// {found, knob} for a controller number
	function automatic logic [3:0] knob_lookup(input logic [6:0] cc);
		logic [3:0] r;
		r = '0;
		for (int k = 7; k >= 0; k--) begin
			if (KNOB_CCS[k] == cc) begin
				r = {1'b1, 3'(k)};
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/midi_voice_allocator.sv
// midi voice allocator: one midi message per input word, voice and control
// events out, one event per output word.
// input: in_valid/in_ready with status_byte, data_first, data_second and
// byte_count; bytes not present reuse the previous message's values.
// output: out_valid/out_ready with event fields; last marks the final event
// of a message. messages that cause no event produce no output word.
// config: cfg_write with cfg_index (0 percussion channel, 1 pickup
// tolerance) and cfg_data, taken at once; write only while idle.
// a front decoder classifies each word into a two-word queue; the back end
// works on one queued message at a time.
// back end per message: a note-off with a matching voice scans over the
// voices, one voice per cycle while no release waits on a stalled receiver;
// a note-on runs the free/highest-note scan, then the voice write; any
// other event goes from idle to a single emit state.
// a stalled receiver holds the output register; the back end waits and the
// queue keeps taking words until it fills, then in_ready drops.
// reset: all voices free, knob store and pickup flags cleared, page 0,
// previous message bytes zero, percussion channel 10, tolerance 3.
module midi_voice_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  data_first,
	input  logic [6:0]  data_second,
	input  logic [1:0]  byte_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_kind,
	output logic [3:0]  voice_index,
	output logic [6:0]  note_number,
	output logic [6:0]  velocity,
	output logic [13:0] control_value,
	output logic [1:0]  page,
	output logic [2:0]  knob_index,
	output logic        last
);

	logic [3:0]    perc_q;
	logic [6:0]    tol_q;
	logic          push;
	mva_pkg::cmd_t push_cmd;
	logic          full;
	logic          pop;
	mva_pkg::cmd_t head;
	logic          head_valid;
	mva_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perc_q <= mva_pkg::PERC_RESET;
			tol_q <= mva_pkg::TOL_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				mva_pkg::CFG_PERC: perc_q <= cfg_data[3:0];
				mva_pkg::CFG_TOL: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mva_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.status_byte (status_byte),
		.data_first  (data_first),
		.data_second (data_second),
		.byte_count  (byte_count),
		.perc_chan   (perc_q),
		.push        (push),
		.push_cmd    (push_cmd),
		.full        (full)
	);

	mva_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	mva_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.tolerance  (tol_q),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign event_kind = res.kind;
	assign voice_index = res.voice;
	assign note_number = res.note;
	assign velocity = res.vel;
	assign control_value = res.cval;
	assign page = res.page;
	assign knob_index = res.knob;
	assign last = res.last;

	// only voice-off messages give more than one event
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != mva_pkg::EV_OFF |-> last)
		else $error("multi-event message on a single-event kind");

	a_voice_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != mva_pkg::EV_ON && event_kind != mva_pkg::EV_OFF
		|-> voice_index == '0 && note_number == '0 && velocity == '0)
		else $error("voice fields set on a control event");

	a_ctrl_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == mva_pkg::EV_BEND || event_kind == mva_pkg::EV_MOD ||
		event_kind == mva_pkg::EV_PWM || event_kind == mva_pkg::EV_WAVE)
		|-> page == '0 && knob_index == '0)
		else $error("page fields set on a plain control event");

endmodule

FILE: sv/mva_front.sv
module mva_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          status_byte,
	input  logic [6:0]          data_first,
	input  logic [6:0]          data_second,
	input  logic [1:0]          byte_count,
	input  logic [3:0]          perc_chan,
	output logic                push,
	output mva_pkg::cmd_t       push_cmd,
	input  logic                full
);

	logic [7:0] last_status_q;
	logic [6:0] last_first_q;
	logic [6:0] last_second_q;

	logic       accept;
	logic [7:0] st;
	logic [6:0] a;
	logic [6:0] b;
	logic [2:0] cmd;
	logic       perc;
	logic [3:0] klu;
	mva_pkg::op_t op;
	logic [2:0] sel;

	assign in_ready = !full;
	assign accept = in_valid && !full;

	// missing bytes fall back to the previous message
	assign st = (byte_count > 2'd0) ? status_byte : last_status_q;
	assign a = (byte_count > 2'd1) ? data_first : last_first_q;
	assign b = (byte_count > 2'd2) ? data_second : last_second_q;
	assign cmd = st[6:4];
	assign perc = (st[3:0] == perc_chan);
	assign klu = mva_pkg::knob_lookup(a);

	always_comb begin
		op = mva_pkg::OP_NONE;
		sel = '0;
		case (cmd)
			mva_pkg::MIDI_NOTE_OFF: begin
				if (!perc) op = mva_pkg::OP_NOTE_OFF;
			end
			mva_pkg::MIDI_NOTE_ON: begin
				if (!perc) op = mva_pkg::OP_NOTE_ON;
			end
			mva_pkg::MIDI_BEND: begin
				if (!perc) op = mva_pkg::OP_BEND;
			end
			mva_pkg::MIDI_CTRL: begin
				case (a) inside
					mva_pkg::CC_MOD: op = mva_pkg::OP_MOD;
					mva_pkg::CC_PWM: op = mva_pkg::OP_PWM;
					mva_pkg::CC_WAVE_A, mva_pkg::CC_WAVE_B: op = mva_pkg::OP_WAVE;
					mva_pkg::CC_PAGE0: begin
						op = mva_pkg::OP_PAGE;
						sel = 3'd0;
					end
					mva_pkg::CC_PAGE1: begin
						op = mva_pkg::OP_PAGE;
						sel = 3'd1;
					end
					mva_pkg::CC_PAGE2: begin
						op = mva_pkg::OP_PAGE;
						sel = 3'd2;
					end
					mva_pkg::CC_PAGE3: begin
						op = mva_pkg::OP_PAGE;
						sel = 3'd3;
					end
					default: begin
						if (klu[3] && (int'(klu[2:0]) < mva_pkg::KNOB_COUNT)) begin
							op = mva_pkg::OP_KNOB;
							sel = klu[2:0];
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		push_cmd.op = op;
		push_cmd.a = a;
		push_cmd.b = b;
		push_cmd.sel = sel;
	end

	assign push = accept && (op != mva_pkg::OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_status_q <= '0;
			last_first_q <= '0;
			last_second_q <= '0;
		end else if (accept) begin
			last_status_q <= st;
			last_first_q <= a;
			last_second_q <= b;
		end
	end

endmodule

FILE: sv/mva_queue.sv
module mva_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mva_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output mva_pkg::cmd_t head,
	output logic          head_valid
);

	localparam int QW = mva_pkg::QPTR_W;
	localparam int CW = mva_pkg::QCNT_W;

	mva_pkg::cmd_t mem_q [mva_pkg::QUEUE_DEPTH];
	logic [QW-1:0] wr_q;
	logic [QW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(mva_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(mva_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QW'(mva_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/mva_back.sv
module mva_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mva_pkg::cmd_t head,
	input  logic          head_valid,
	output logic          pop,
	input  logic [6:0]    tolerance,
	output logic          res_valid,
	input  logic          res_ready,
	output mva_pkg::res_t res
);

	localparam int VC = mva_pkg::VOICE_COUNT;
	localparam int VW = mva_pkg::VOICE_W;
	localparam int KC = mva_pkg::KNOB_COUNT;
	localparam int KW = mva_pkg::KIDX_W;
	localparam int SC = mva_pkg::SLOT_COUNT;
	localparam int SW = mva_pkg::SLOT_W;
	localparam int CW = mva_pkg::CNT_W;

	mva_pkg::bk_state_t state_q, state_d;
	mva_pkg::cmd_t      cur_q;
	logic [VW-1:0]      i_q;
	logic [VW-1:0]      pick_q;
	logic [6:0]         best_q;
	logic [VC-1:0]      mask_q;
	logic [CW-1:0]      cnt_q;
	logic [7:0]         voice_q [VC];
	logic [6:0]         knob_q [SC];
	logic [KC-1:0]      flag_q;
	logic [1:0]         page_q;
	logic               res_valid_q;
	mva_pkg::res_t      res_q;

	logic               slot_free;
	logic               last_i;
	logic [VC-1:0]      match;
	logic               off_bit;
	logic               off_last;
	logic               off_adv;
	logic               cur_free;
	logic [6:0]         cur_note;
	logic [KW-1:0]      ki;
	logic [SW-1:0]      slot;
	logic [6:0]         stored;
	logic [6:0]         diff;
	logic               knob_ok;
	logic               emit;
	mva_pkg::res_t      res_d;

	assign slot_free = !res_valid_q || res_ready;
	assign last_i = (i_q == VW'(VC - 1));

	always_comb begin
		for (int v = 0; v < VC; v++) begin
			match[v] = (voice_q[v] == {1'b0, head.a});
		end
	end

	// last release when no matched voice lies above, or the result cap is hit
	assign off_bit = mask_q[i_q];
	assign off_last = (((mask_q >> i_q) >> 1) == '0) ||
		(cnt_q == CW'(mva_pkg::MAX_RESULTS - 1));
	assign off_adv = !off_bit || slot_free;

	assign cur_free = voice_q[i_q][7];
	assign cur_note = voice_q[i_q][6:0];

	assign ki = cur_q.sel[KW-1:0];
	assign slot = SW'(SW'(page_q) * SW'(KC) + SW'(ki));
	assign stored = knob_q[slot];
	assign diff = (stored >= cur_q.b) ? stored - cur_q.b : cur_q.b - stored;
	assign knob_ok = !flag_q[ki] || (diff <= tolerance);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mva_pkg::BK_IDLE: begin
				if (head_valid) begin
					case (head.op)
						mva_pkg::OP_NOTE_OFF: state_d = (|match) ? mva_pkg::BK_OFF_SCAN
							: mva_pkg::BK_IDLE;
						mva_pkg::OP_NOTE_ON: state_d = mva_pkg::BK_ON_SCAN;
						default: state_d = mva_pkg::BK_SINGLE;
					endcase
				end
			end
			mva_pkg::BK_OFF_SCAN: begin
				if (off_adv && (last_i || (off_bit && off_last))) state_d = mva_pkg::BK_IDLE;
			end
			mva_pkg::BK_ON_SCAN: begin
				if (cur_free || last_i) state_d = mva_pkg::BK_ON_EMIT;
			end
			mva_pkg::BK_ON_EMIT: begin
				if (slot_free) state_d = mva_pkg::BK_IDLE;
			end
			mva_pkg::BK_SINGLE: begin
				if (slot_free || (cur_q.op == mva_pkg::OP_KNOB && !knob_ok)) begin
					state_d = mva_pkg::BK_IDLE;
				end
			end
			default: state_d = mva_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		emit = 1'b0;
		res_d = '0;
		case (state_q)
			mva_pkg::BK_IDLE: pop = head_valid;
			mva_pkg::BK_OFF_SCAN: begin
				emit = off_bit && slot_free;
				res_d.kind = mva_pkg::EV_OFF;
				res_d.voice = 4'(i_q);
				res_d.note = cur_q.a;
				res_d.last = off_last;
			end
			mva_pkg::BK_ON_EMIT: begin
				emit = slot_free;
				res_d.kind = mva_pkg::EV_ON;
				res_d.voice = 4'(pick_q);
				res_d.note = cur_q.a;
				res_d.vel = cur_q.b;
				res_d.last = 1'b1;
			end
			mva_pkg::BK_SINGLE: begin
				emit = slot_free && (cur_q.op != mva_pkg::OP_KNOB || knob_ok);
				res_d.last = 1'b1;
				case (cur_q.op)
					mva_pkg::OP_BEND: begin
						res_d.kind = mva_pkg::EV_BEND;
						res_d.cval = {cur_q.b, cur_q.a};
					end
					mva_pkg::OP_MOD: begin
						res_d.kind = mva_pkg::EV_MOD;
						res_d.cval = {7'd0, cur_q.b};
					end
					mva_pkg::OP_PWM: begin
						res_d.kind = mva_pkg::EV_PWM;
						res_d.cval = {7'd0, cur_q.b};
					end
					mva_pkg::OP_WAVE: begin
						res_d.kind = mva_pkg::EV_WAVE;
						res_d.cval = {7'd0, cur_q.b};
					end
					mva_pkg::OP_PAGE: begin
						res_d.kind = mva_pkg::EV_PAGE;
						res_d.page = cur_q.sel[1:0];
					end
					mva_pkg::OP_KNOB: begin
						res_d.kind = mva_pkg::EV_KNOB;
						res_d.cval = {7'd0, cur_q.b};
						res_d.page = page_q;
						res_d.knob = cur_q.sel;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mva_pkg::BK_IDLE;
			i_q <= '0;
			cnt_q <= '0;
			mask_q <= '0;
			for (int v = 0; v < VC; v++) voice_q[v] <= mva_pkg::VOICE_FREE;
			for (int s = 0; s < SC; s++) knob_q[s] <= '0;
			flag_q <= '0;
			page_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mva_pkg::BK_IDLE: begin
					if (pop) begin
						i_q <= '0;
						cnt_q <= '0;
						mask_q <= match;
						// note-off frees all matching voices up front
						if (head.op == mva_pkg::OP_NOTE_OFF) begin
							for (int v = 0; v < VC; v++) begin
								if (match[v]) voice_q[v] <= mva_pkg::VOICE_FREE;
							end
						end
					end
				end
				mva_pkg::BK_OFF_SCAN: begin
					if (off_adv) i_q <= i_q + 1'b1;
					if (emit) cnt_q <= cnt_q + 1'b1;
				end
				mva_pkg::BK_ON_SCAN: i_q <= i_q + 1'b1;
				mva_pkg::BK_ON_EMIT: begin
					if (slot_free) voice_q[pick_q] <= {1'b0, cur_q.a};
				end
				mva_pkg::BK_SINGLE: begin
					if (emit && cur_q.op == mva_pkg::OP_PAGE) begin
						page_q <= cur_q.sel[1:0];
						flag_q <= '1;
					end
					if (emit && cur_q.op == mva_pkg::OP_KNOB) begin
						flag_q[ki] <= 1'b0;
						knob_q[slot] <= cur_q.b;
					end
				end
				default: ;
			endcase
			if (emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (state_q == mva_pkg::BK_ON_SCAN) begin
			if (cur_free) begin
				pick_q <= i_q;
			end else if (i_q == '0 || cur_note > best_q) begin
				best_q <= cur_note;
				pick_q <= i_q;
			end
		end
		if (emit) res_q <= res_d;
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

FILE: tb/midi_event_checker.sv
`timescale 1ns / 1ps

module midi_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  status_byte,
	input  logic [6:0]  data_first,
	input  logic [6:0]  data_second,
	input  logic [1:0]  byte_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  event_kind,
	input  logic [3:0]  voice_index,
	input  logic [6:0]  note_number,
	input  logic [6:0]  velocity,
	input  logic [13:0] control_value,
	input  logic [1:0]  page,
	input  logic [2:0]  knob_index,
	input  logic        last,
	output int          fail_count,
	output int          pending
);

	logic [7:0] voice_notes [mva_pkg::VOICE_COUNT];
	logic [6:0] knob_store [mva_pkg::SLOT_COUNT];
	logic       pickup_armed [mva_pkg::KNOB_COUNT];
	logic [1:0] cur_page;
	logic [7:0] prev_status;
	logic [6:0] prev_first;
	logic [6:0] prev_second;
	logic [3:0] perc_chan;
	logic [6:0] tolerance;

	mva_pkg::res_t due_events [$];
	int            msg_events;

	task automatic push_event(input mva_pkg::ev_kind_t kind, input logic [3:0] voice,
		input logic [6:0] note, input logic [6:0] vel, input logic [13:0] cval,
		input logic [1:0] pg, input logic [2:0] knob);
		mva_pkg::res_t r;
		if (msg_events < mva_pkg::MAX_RESULTS) begin
			r.kind = kind;
			r.voice = voice;
			r.note = note;
			r.vel = vel;
			r.cval = cval;
			r.page = pg;
			r.knob = knob;
			r.last = 1'b0;
			due_events.push_back(r);
			msg_events++;
		end
	endtask

	task automatic knob_turn(input int k, input logic [6:0] v);
		int slot;
		int diff;
		slot = int'(cur_page) * mva_pkg::KNOB_COUNT + k;
		diff = int'(knob_store[slot]) - int'(v);
		if (diff < 0) diff = -diff;
		// soft takeover: armed knob must come close to the stored value first
		if (pickup_armed[k] && diff > int'(tolerance)) return;
		pickup_armed[k] = 1'b0;
		knob_store[slot] = v;
		push_event(mva_pkg::EV_KNOB, 4'd0, 7'd0, 7'd0, {7'd0, v}, cur_page, 3'(k));
	endtask

	task automatic select_page(input logic [1:0] p);
		cur_page = p;
		for (int k = 0; k < mva_pkg::KNOB_COUNT; k++) pickup_armed[k] = 1'b1;
		push_event(mva_pkg::EV_PAGE, 4'd0, 7'd0, 7'd0, 14'd0, cur_page, 3'd0);
	endtask

	task automatic control_change(input logic [6:0] cc, input logic [6:0] v);
		if (cc == mva_pkg::CC_MOD) begin
			push_event(mva_pkg::EV_MOD, 4'd0, 7'd0, 7'd0, {7'd0, v}, 2'd0, 3'd0);
		end else if (cc == mva_pkg::CC_PWM) begin
			push_event(mva_pkg::EV_PWM, 4'd0, 7'd0, 7'd0, {7'd0, v}, 2'd0, 3'd0);
		end else if (cc == mva_pkg::CC_WAVE_A || cc == mva_pkg::CC_WAVE_B) begin
			push_event(mva_pkg::EV_WAVE, 4'd0, 7'd0, 7'd0, {7'd0, v}, 2'd0, 3'd0);
		end else if (cc == mva_pkg::CC_PAGE0) begin
			select_page(2'd0);
		end else if (cc == mva_pkg::CC_PAGE1) begin
			select_page(2'd1);
		end else if (cc == mva_pkg::CC_PAGE2) begin
			select_page(2'd2);
		end else if (cc == mva_pkg::CC_PAGE3) begin
			select_page(2'd3);
		end else begin
			for (int k = 0; k < 8; k++) begin
				if (mva_pkg::KNOB_CCS[k] == cc) begin
					if (k < mva_pkg::KNOB_COUNT) knob_turn(k, v);
					break;
				end
			end
		end
	endtask

	task automatic play_message(input logic [7:0] st, input logic [6:0] d1,
		input logic [6:0] d2, input logic [1:0] cnt);
		logic [2:0]    cmd;
		logic [3:0]    chan;
		logic [6:0]    a;
		logic [6:0]    b;
		int            pick;
		logic [7:0]    best;
		mva_pkg::res_t r;
		msg_events = 0;
		// running status: missing bytes keep the previous message's values
		if (cnt > 2'd0) prev_status = st;
		if (cnt > 2'd1) prev_first = d1;
		if (cnt > 2'd2) prev_second = d2;
		cmd = prev_status[6:4];
		chan = prev_status[3:0];
		a = prev_first;
		b = prev_second;
		case (cmd)
			mva_pkg::MIDI_NOTE_OFF: begin
				if (chan != perc_chan) begin
					for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) begin
						if (voice_notes[i] == {1'b0, a}) begin
							voice_notes[i] = mva_pkg::VOICE_FREE;
							push_event(mva_pkg::EV_OFF, 4'(i), a, 7'd0, 14'd0, 2'd0, 3'd0);
						end
					end
				end
			end
			mva_pkg::MIDI_NOTE_ON: begin
				if (chan != perc_chan) begin
					pick = -1;
					for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) begin
						if (voice_notes[i][7]) begin
							pick = i;
							break;
						end
					end
					// all busy: steal highest note, lowest index on a tie
					if (pick < 0) begin
						pick = 0;
						best = voice_notes[0];
						for (int i = 1; i < mva_pkg::VOICE_COUNT; i++) begin
							if (voice_notes[i] > best) begin
								best = voice_notes[i];
								pick = i;
							end
						end
					end
					voice_notes[pick] = {1'b0, a};
					push_event(mva_pkg::EV_ON, 4'(pick), a, b, 14'd0, 2'd0, 3'd0);
				end
			end
			mva_pkg::MIDI_CTRL: control_change(a, b);
			mva_pkg::MIDI_BEND: begin
				if (chan != perc_chan)
					push_event(mva_pkg::EV_BEND, 4'd0, 7'd0, 7'd0, {b, a}, 2'd0, 3'd0);
			end
			default: ;
		endcase
		if (msg_events > 0) begin
			r = due_events.pop_back();
			r.last = 1'b1;
			due_events.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mva_pkg::res_t r;
		if (!arst_n) begin
			for (int i = 0; i < mva_pkg::VOICE_COUNT; i++) voice_notes[i] = mva_pkg::VOICE_FREE;
			for (int i = 0; i < mva_pkg::SLOT_COUNT; i++) knob_store[i] = 7'd0;
			for (int i = 0; i < mva_pkg::KNOB_COUNT; i++) pickup_armed[i] = 1'b0;
			cur_page = 2'd0;
			prev_status = 8'd0;
			prev_first = 7'd0;
			prev_second = 7'd0;
			perc_chan = mva_pkg::PERC_RESET;
			tolerance = mva_pkg::TOL_RESET;
			due_events.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// an output word always belongs to an older message than a new input word
			if (out_valid && out_ready) begin
				if (due_events.size() == 0) begin
					$error("event word with nothing due: kind %0d voice %0d value %0d",
						event_kind, voice_index, control_value);
					fail_count++;
				end else begin
					r = due_events.pop_front();
					check_field("event_kind", r.kind, event_kind);
					check_field("voice_index", r.voice, voice_index);
					check_field("note_number", r.note, note_number);
					check_field("velocity", r.vel, velocity);
					check_field("control_value", r.cval, control_value);
					check_field("page", r.page, page);
					check_field("knob_index", r.knob, knob_index);
					check_field("last", r.last, last);
				end
			end
			if (cfg_write) begin
				if (cfg_index == mva_pkg::CFG_PERC) perc_chan = cfg_data[3:0];
				else tolerance = cfg_data;
			end
			if (in_valid && in_ready)
				play_message(status_byte, data_first, data_second, byte_count);
			pending = due_events.size();
		end
	end

endmodule

FILE: tb/midi_voice_allocator_tb.sv
`timescale 1ns / 1ps

module midi_voice_allocator_tb;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 85;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;

	// {status, first, second, count}
	localparam logic [23:0] DIRECTED [28] = '{
		{8'h80, 7'd5, 7'd0, 2'd3},
		{8'h90, 7'd127, 7'd0, 2'd3},
		{8'h91, 7'd0, 7'd127, 2'd3},
		{8'h9A, 7'd60, 7'd100, 2'd3},
		{8'h8A, 7'd60, 7'd0, 2'd3},
		{8'hE3, 7'd127, 7'd127, 2'd3},
		{8'hEA, 7'd0, 7'd0, 2'd3},
		{8'hE0, 7'd0, 7'd0, 2'd3},
		{8'hB0, 7'd1, 7'd127, 2'd3},
		{8'hB0, 7'd2, 7'd0, 2'd3},
		{8'hB0, 7'd64, 7'd33, 2'd3},
		{8'hB0, 7'd65, 7'd90, 2'd3},
		{8'hB0, 7'd20, 7'd5, 2'd3},
		{8'hB0, 7'd91, 7'd127, 2'd3},
		{8'hB0, 7'd10, 7'd7, 2'd3},
		{8'hBF, 7'd96, 7'd0, 2'd3},
		{8'hB0, 7'd93, 7'd100, 2'd3},
		{8'hB0, 7'd93, 7'd2, 2'd3},
		{8'hB0, 7'd97, 7'd0, 2'd3},
		{8'hB0, 7'd66, 7'd0, 2'd3},
		{8'hB0, 7'd67, 7'd0, 2'd3},
		{8'hA5, 7'd3, 7'd3, 2'd3},
		{8'hFF, 7'd127, 7'd127, 2'd3},
		{8'h15, 7'd42, 7'd64, 2'd3},
		{8'h92, 7'd0, 7'd0, 2'd1},
		{8'h00, 7'd0, 7'd0, 2'd0},
		{8'h80, 7'd42, 7'd0, 2'd2},
		{8'h81, 7'd127, 7'd0, 2'd3}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_data = 7'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  status_byte = 8'd0;
	logic [6:0]  data_first = 7'd0;
	logic [6:0]  data_second = 7'd0;
	logic [1:0]  byte_count = 2'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_kind;
	logic [3:0]  voice_index;
	logic [6:0]  note_number;
	logic [6:0]  velocity;
	logic [13:0] control_value;
	logic [1:0]  page;
	logic [2:0]  knob_index;
	logic        last;

	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	int         sent_items = 0;
	bit         no_gaps = 1'b0;
	bit         hold_req = 1'b0;
	logic [3:0] perc_chan = mva_pkg::PERC_RESET;

	midi_voice_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.status_byte(status_byte), .data_first(data_first),
		.data_second(data_second), .byte_count(byte_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .voice_index(voice_index),
		.note_number(note_number), .velocity(velocity),
		.control_value(control_value), .page(page),
		.knob_index(knob_index), .last(last)
	);

	midi_event_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.status_byte(status_byte), .data_first(data_first),
		.data_second(data_second), .byte_count(byte_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .voice_index(voice_index),
		.note_number(note_number), .velocity(velocity),
		.control_value(control_value), .page(page),
		.knob_index(knob_index), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] status_of(input logic [2:0] cmd, input logic [3:0] chan);
		return {($urandom_range(0, 9) != 0), cmd, chan};
	endfunction

	function automatic logic [1:0] count_of();
		if ($urandom_range(0, 9) == 0) return 2'($urandom_range(0, 2));
		return 2'd3;
	endfunction

	function automatic logic [3:0] chan_of();
		if ($urandom_range(0, 4) == 0) return perc_chan;
		return 4'($urandom_range(0, 15));
	endfunction

	// small pool so notes collide, voices fill up and get stolen
	function automatic logic [6:0] note_of();
		if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
		return 7'($urandom_range(40, 47));
	endfunction

	function automatic logic [6:0] knob_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 7'($urandom_range(61, 67));
		if (r < 75) return 7'($urandom_range(0, 5));
		return 7'($urandom_range(0, 127));
	endfunction

	task automatic send_word(input logic [7:0] st, input logic [6:0] d1,
		input logic [6:0] d2, input logic [1:0] cnt);
		int gap;
		in_valid <= 1'b1;
		status_byte <= st;
		data_first <= d1;
		data_second <= d2;
		byte_count <= cnt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
		gap = no_gaps ? 0 : rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// words with no event may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [3:0] perc, input logic [6:0] tol);
		cfg_write <= 1'b1;
		cfg_index <= mva_pkg::CFG_PERC;
		cfg_data <= {3'd0, perc};
		@(posedge clk);
		cfg_index <= mva_pkg::CFG_TOL;
		cfg_data <= tol;
		@(posedge clk);
		cfg_write <= 1'b0;
		perc_chan = perc;
	endtask

	task automatic random_sequence();
		int         kind;
		int         n;
		logic [3:0] chan;
		logic [6:0] note;
		logic [6:0] cc;
		kind = $urandom_range(0, 99);
		no_gaps = ($urandom_range(0, 3) == 0);
		if (kind < 30) begin
			n = $urandom_range(1, 20);
			for (int i = 0; i < n; i++)
				send_word(status_of(mva_pkg::MIDI_NOTE_ON, chan_of()), note_of(),
					7'($urandom_range(0, 127)), count_of());
		end else if (kind < 50) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_word(status_of(mva_pkg::MIDI_NOTE_OFF, chan_of()), note_of(),
					7'($urandom_range(0, 127)), count_of());
		end else if (kind < 53) begin
			// low note on every voice, then one note-off frees them all
			chan = perc_chan + 4'd1;
			note = 7'($urandom_range(0, 39));
			for (int i = 0; i < mva_pkg::VOICE_COUNT; i++)
				send_word({1'b1, mva_pkg::MIDI_NOTE_ON, chan}, note,
					7'($urandom_range(0, 127)), 2'd3);
			send_word({1'b1, mva_pkg::MIDI_NOTE_OFF, chan}, note, 7'd0, 2'd3);
		end else if (kind < 65) begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 4))
					0: cc = mva_pkg::CC_MOD;
					1: cc = mva_pkg::CC_PWM;
					2: cc = mva_pkg::CC_WAVE_A;
					3: cc = mva_pkg::CC_WAVE_B;
					default: cc = 7'($urandom_range(0, 127));
				endcase
				send_word(status_of(mva_pkg::MIDI_CTRL, 4'($urandom_range(0, 15))), cc,
					7'($urandom_range(0, 127)), count_of());
			end
		end else if (kind < 80) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: cc = mva_pkg::CC_PAGE0;
					1: cc = mva_pkg::CC_PAGE1;
					2: cc = mva_pkg::CC_PAGE2;
					default: cc = mva_pkg::CC_PAGE3;
				endcase
				send_word(status_of(mva_pkg::MIDI_CTRL, 4'($urandom_range(0, 15))), cc,
					7'($urandom_range(0, 127)), 2'd3);
			end
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_word(status_of(mva_pkg::MIDI_CTRL, 4'($urandom_range(0, 15))),
					mva_pkg::KNOB_CCS[$urandom_range(0, 7)], knob_value(), count_of());
		end else if (kind < 88) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				send_word(status_of(mva_pkg::MIDI_BEND, chan_of()),
					7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), count_of());
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_word(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
					7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
		end
	endtask

	// receiver side
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold so the input side backs up
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			stall = rand_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 28; i++)
			send_word(DIRECTED[i][23:16], DIRECTED[i][15:9], DIRECTED[i][8:2],
				DIRECTED[i][1:0]);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: configure(mva_pkg::PERC_RESET, mva_pkg::TOL_RESET);
				1: configure(4'd0, 7'd0);
				2: configure(4'd15, 7'd127);
				default: configure(4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
			endcase
			if (phase == 0) hold_req = 1'b1;
			while (sent_items < (phase + 1) * PHASE_ITEMS) random_sequence();
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/mva_pkg.sv
sv/mva_front.sv
sv/mva_queue.sv
sv/mva_back.sv
sv/midi_voice_allocator.sv
tb/midi_event_checker.sv
tb/midi_voice_allocator_tb.sv
